// ===== sv/u8dt_pkg.sv =====
// Shared types, constants and the transliteration ROM for the UTF-8 decoder.
// No dependencies; imported by utf8_decode_transliterate_top.
package u8dt_pkg;

   localparam int CpWidth = 21;

   // Result queue depth; the top level's count and ready threshold assume three
   localparam int QDepth = 3;

   localparam logic [CpWidth-1:0] SubstCp     = 21'h00FFFD;
   localparam logic [7:0]         LeadMin     = 8'hC2;
   localparam logic [7:0]         LeadMax     = 8'hF4;
   localparam logic [7:0]         Lead3Min    = 8'hE0;
   localparam logic [7:0]         Lead4Min    = 8'hF0;
   localparam logic [7:0]         AsciiLimit  = 8'h80;
   localparam logic [1:0]         ContTag     = 2'b10;

   // One ROM answer: hit flag, character count, packed characters
   typedef struct packed {
      logic        hit;
      logic [2:0]  len;
      logic [31:0] chars;
   } rom_entry_type;

   // One queued result item
   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               decode_error;
      logic               table_hit;
      logic [2:0]         replacement_length;
      logic [31:0]        replacement_chars;
      logic               last_of_run;
   } rsp_item_type;

   // Build a ROM answer from a right-aligned string literal of n characters;
   // the first character lands in the low byte.
   function automatic rom_entry_type mk_entry(input logic [2:0] n, input logic [31:0] s);
      rom_entry_type e;
      int            k;
      e.hit   = 1'b1;
      e.len   = n;
      e.chars = '0;
      for (int i = 0; i < 4; i++) begin
         k = int'(n) - 1 - i;
         if (k >= 0) begin
            e.chars[8*i +: 8] = s[8*k +: 8];
         end
      end
      return e;
   endfunction

   // Transliteration table lookup
   function automatic rom_entry_type rom_lookup(input logic [CpWidth-1:0] cp);
      rom_entry_type e;
      e = '0;
      case (cp)
         21'h00A0: e = mk_entry(3'd1, " ");
         21'h00A9: e = mk_entry(3'd3, "(c)");
         21'h00AB, 21'h00BB: e = mk_entry(3'd1, "\"");
         21'h00AE: e = mk_entry(3'd3, "(r)");
         21'h00B4: e = mk_entry(3'd1, "'");
         21'h00B7: e = mk_entry(3'd1, ".");
         21'h00C0, 21'h00C1, 21'h00C2, 21'h00C3, 21'h00C4, 21'h00C5:
            e = mk_entry(3'd1, "A");
         21'h00C6: e = mk_entry(3'd2, "AE");
         21'h00C7: e = mk_entry(3'd1, "C");
         21'h00C8, 21'h00C9, 21'h00CA, 21'h00CB: e = mk_entry(3'd1, "E");
         21'h00CC, 21'h00CD, 21'h00CE, 21'h00CF: e = mk_entry(3'd1, "I");
         21'h00D0: e = mk_entry(3'd1, "D");
         21'h00D1: e = mk_entry(3'd1, "N");
         21'h00D2, 21'h00D3, 21'h00D4, 21'h00D5, 21'h00D6, 21'h00D8:
            e = mk_entry(3'd1, "O");
         21'h00D7: e = mk_entry(3'd1, "x");
         21'h00D9, 21'h00DA, 21'h00DB, 21'h00DC: e = mk_entry(3'd1, "U");
         21'h00DD: e = mk_entry(3'd1, "Y");
         21'h00DF: e = mk_entry(3'd2, "ss");
         21'h00E0, 21'h00E1, 21'h00E2, 21'h00E3, 21'h00E4, 21'h00E5:
            e = mk_entry(3'd1, "a");
         21'h00E6: e = mk_entry(3'd2, "ae");
         21'h00E7: e = mk_entry(3'd1, "c");
         21'h00E8, 21'h00E9, 21'h00EA, 21'h00EB: e = mk_entry(3'd1, "e");
         21'h00EC, 21'h00ED, 21'h00EE, 21'h00EF: e = mk_entry(3'd1, "i");
         21'h00F0: e = mk_entry(3'd1, "d");
         21'h00F1: e = mk_entry(3'd1, "n");
         21'h00F2, 21'h00F3, 21'h00F4, 21'h00F5, 21'h00F6, 21'h00F8:
            e = mk_entry(3'd1, "o");
         21'h00F7: e = mk_entry(3'd1, "/");
         21'h00F9, 21'h00FA, 21'h00FB, 21'h00FC: e = mk_entry(3'd1, "u");
         21'h00FD, 21'h00FF: e = mk_entry(3'd1, "y");
         21'h0152: e = mk_entry(3'd2, "OE");
         21'h0153: e = mk_entry(3'd2, "oe");
         21'h0160: e = mk_entry(3'd1, "S");
         21'h0161: e = mk_entry(3'd1, "s");
         21'h017D: e = mk_entry(3'd1, "Z");
         21'h017E: e = mk_entry(3'd1, "z");
         21'h2013: e = mk_entry(3'd1, "-");
         21'h2014: e = mk_entry(3'd2, "--");
         21'h2018, 21'h2019: e = mk_entry(3'd1, "'");
         21'h201A: e = mk_entry(3'd1, ",");
         21'h201C, 21'h201D, 21'h201E: e = mk_entry(3'd1, "\"");
         21'h2020: e = mk_entry(3'd1, "+");
         21'h2022: e = mk_entry(3'd1, "*");
         21'h2026: e = mk_entry(3'd3, "...");
         21'h2039: e = mk_entry(3'd1, "<");
         21'h203A: e = mk_entry(3'd1, ">");
         21'h20AC: e = mk_entry(3'd3, "EUR");
         21'h2122: e = mk_entry(3'd4, "(tm)");
         default:  e = '0;
      endcase
      return e;
   endfunction

endpackage

// ===== sv/utf8_decode_transliterate_top.sv =====
// UTF-8 decoder with ASCII transliteration: byte stream in, code points out.
// Depends on u8dt_pkg for the result type, constants and the transliteration ROM.
//
//  channel | dir | tdata                | tuser                        | tlast
//  req_    | in  | [7:0] byte_value     | -                            | last_byte
//  rsp_    | out | [20:0] code_point,   | [0] decode_error,            | last_of_run
//          |     | [23:21] repl_length, | [1] table_hit                |
//          |     | [55:24] repl_chars   |                              |
//
// One byte is accepted per cycle while req_tready is high; decode and ROM match
// sit between the byte input and a three-entry result queue. A byte gives 0, 1
// or 2 results and the result port drains one per cycle while rsp_tready is high.
// req_tready is high while the queue holds at most one result.
// Synchronous active-high reset clears the decoder state and empties the queue.
// A stalled result port fills the queue and then holds off further bytes.
module utf8_decode_transliterate_top
   import u8dt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] byte_value
   input  logic        req_tlast,    // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // [20:0] code_point, [23:21] replacement_length,
                                     // [55:24] replacement_chars
   output logic [1:0]  rsp_tuser,    // [0] decode_error, [1] table_hit
   output logic        rsp_tlast     // last_of_run
);

   logic [CpWidth-1:0] part_ff, part_in;
   logic [1:0]         need_ff, need_in;
   rsp_item_type       q_ff [QDepth];
   rsp_item_type       q_in [QDepth];
   logic [1:0]         cnt_ff, cnt_in;

   logic               req_fire, rsp_fire;
   logic [7:0]         b;
   logic               pend, cont, lead_ok;
   logic [CpWidth-1:0] data_cp;
   logic [2:0]         ev_v, ev_e;
   logic [1:0]         n_res, cnt_p;
   logic               k0_err, k1_err;
   rom_entry_type      rom_e;
   rsp_item_type       s0, s1, err_item, data_item;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign b        = req_tdata;
   assign pend     = (need_ff != 2'd0);
   assign cont     = (b[7:6] == ContTag);
   assign lead_ok  = (b >= LeadMin) && (b <= LeadMax);

   // Decode one byte: three ordered events (continuation, lead, truncation)
   always_comb begin
      part_in = part_ff;
      need_in = need_ff;
      data_cp = {{(CpWidth-8){1'b0}}, b};
      ev_v    = '0;
      ev_e    = '0;
      // continuation or broken sequence
      if (pend) begin
         if (cont) begin
            part_in = {part_ff[CpWidth-7:0], b[5:0]};
            need_in = need_ff - 2'd1;
            if (need_in == 2'd0) begin
               ev_v[0] = 1'b1;
               data_cp = part_in;
               part_in = '0;
            end
         end else begin
            ev_v[0] = 1'b1;
            ev_e[0] = 1'b1;
            need_in = 2'd0;
            part_in = '0;
         end
      end
      // lead byte
      if (!pend || !cont) begin
         if (b < AsciiLimit) begin
            ev_v[1] = 1'b1;
         end else if (!lead_ok) begin
            ev_v[1] = 1'b1;
            ev_e[1] = 1'b1;
         end else if (b < Lead3Min) begin
            part_in = {{(CpWidth-5){1'b0}}, b[4:0]};
            need_in = 2'd1;
         end else if (b < Lead4Min) begin
            part_in = {{(CpWidth-4){1'b0}}, b[3:0]};
            need_in = 2'd2;
         end else begin
            part_in = {{(CpWidth-3){1'b0}}, b[2:0]};
            need_in = 2'd3;
         end
      end
      // truncated sequence at end of text
      if (req_tlast && (need_in != 2'd0)) begin
         ev_v[2] = 1'b1;
         ev_e[2] = 1'b1;
         need_in = 2'd0;
         part_in = '0;
      end
   end

   // Pick the first and second present events
   always_comb begin
      n_res  = 2'(ev_v[0]) + 2'(ev_v[1]) + 2'(ev_v[2]);
      k0_err = ev_v[0] ? ev_e[0] : (ev_v[1] ? ev_e[1] : ev_e[2]);
      k1_err = ev_v[0] ? (ev_v[1] ? ev_e[1] : ev_e[2]) : ev_e[2];
   end

   // Build result items; only a data result goes through the ROM
   always_comb begin
      rom_e = rom_lookup(data_cp);
      err_item.code_point         = SubstCp;
      err_item.decode_error       = 1'b1;
      err_item.table_hit          = 1'b0;
      err_item.replacement_length = 3'd0;
      err_item.replacement_chars  = '0;
      err_item.last_of_run        = 1'b0;
      data_item.code_point         = data_cp;
      data_item.decode_error       = 1'b0;
      data_item.table_hit          = rom_e.hit;
      data_item.replacement_length = rom_e.len;
      data_item.replacement_chars  = rom_e.chars;
      data_item.last_of_run        = 1'b0;
      s0 = k0_err ? err_item : data_item;
      s1 = k1_err ? err_item : data_item;
      s0.last_of_run = (n_res == 2'd1);
      s1.last_of_run = 1'b1;
   end

   // Queue update: pop from the head, push up to two behind what remains
   always_comb begin
      cnt_p = cnt_ff - 2'(rsp_fire);
      for (int i = 0; i < QDepth; i++) begin
         if (rsp_fire && (i < QDepth - 1)) begin
            q_in[i] = q_ff[i+1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (req_fire && (n_res != 2'd0) && (2'(i) == cnt_p)) begin
            q_in[i] = s0;
         end
         if (req_fire && (n_res == 2'd2) && (2'(i) == cnt_p + 2'd1)) begin
            q_in[i] = s1;
         end
      end
      cnt_in = req_fire ? cnt_p + n_res : cnt_p;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= '0;
         need_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (req_fire) begin
            part_ff <= part_in;
            need_ff <= need_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < QDepth; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   assign req_tready = (cnt_ff <= 2'd1);
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {q_ff[0].replacement_chars, q_ff[0].replacement_length,
                        q_ff[0].code_point};
   assign rsp_tuser  = {q_ff[0].table_hit, q_ff[0].decode_error};
   assign rsp_tlast  = q_ff[0].last_of_run;

   // No sequence stays open past the end of the text
   a_trunc_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> need_ff == 2'd0)
      else $error("sequence pending after last byte");

   // Partial value is zero whenever nothing is pending
   a_part_idle: assert property (@(posedge clock) disable iff (reset)
      need_ff == 2'd0 |-> part_ff == '0)
      else $error("stale partial value");

   // Error results carry the substitute and no replacement
   a_err_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[20:0] == SubstCp && !rsp_tuser[1])
      else $error("malformed error item");

   // Hit flag agrees with replacement length
   a_hit_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[1] == (rsp_tdata[23:21] != 3'd0))
      else $error("hit flag and length disagree");

endmodule
